### rtl/cqe_pkg.sv
`default_nettype none

package cqe_pkg;

  localparam int CAP_W    = 7;
  localparam int FUNC_W   = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } cqe_state_t;

  typedef struct packed {
    logic                enq;
    logic                deq;
    logic                disp;
    logic                resp;
    logic [STATUS_W-1:0] resp_status;
    logic                emit;
  } cqe_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic last_pend;
  } cqe_stat_t;

endpackage

`default_nettype wire

### rtl/cqe_in_if.sv
`default_nettype none

interface cqe_in_if import cqe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

### rtl/cqe_out_if.sv
`default_nettype none

interface cqe_out_if import cqe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] data;
  logic                     last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

### rtl/cqe_ctrl.sv
`default_nettype none

module cqe_ctrl import cqe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  input  cqe_stat_t         stat,
  output cqe_cmd_t          cmd
);

  cqe_state_t state_r;
  cqe_state_t state_nxt;
  logic       fire;

  assign in_ready = (state_r == ST_IDLE) && stat.out_free;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire && !stat.empty && (in_func == FUNC_DEQ || in_func == FUNC_DISP)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free && stat.last_pend) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          unique case (in_func)
            FUNC_ENQ: begin
              cmd.resp = 1'b1;
              if (stat.full) begin
                cmd.resp_status = STATUS_OVERFLOW;
              end else begin
                cmd.enq         = 1'b1;
                cmd.resp_status = STATUS_OK;
              end
            end
            FUNC_DEQ: begin
              if (stat.empty) begin
                cmd.resp        = 1'b1;
                cmd.resp_status = STATUS_UNDERFLOW;
              end else begin
                cmd.deq = 1'b1;
              end
            end
            FUNC_DISP: begin
              if (stat.empty) begin
                cmd.resp        = 1'b1;
                cmd.resp_status = STATUS_UNDERFLOW;
              end else begin
                cmd.disp = 1'b1;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/cqe_dpath.sv
`default_nettype none

module cqe_dpath import cqe_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic signed [WORD_W-1:0] in_value,
  input  cqe_cmd_t                 cmd,
  output cqe_stat_t                stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [WORD_W-1:0] out_data,
  output logic                     out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (int'(c) > DEPTH) begin
      r = CW'(DEPTH);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx, input logic [CW-1:0] cap);
    logic [CW-1:0] inc;
    inc = CW'(idx) + CW'(1);
    return (inc >= cap) ? '0 : IW'(inc);
  endfunction

  logic [WORD_W-1:0]        mem [DEPTH];
  logic [WORD_W-1:0]        rd_data_r;
  logic [IW-1:0]            head_r, head_nxt;
  logic [IW-1:0]            tail_r, tail_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            remain_r, remain_nxt;
  logic [CW-1:0]            cap_r, cap_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r;
  logic signed [WORD_W-1:0] out_data_r;
  logic                     out_last_r;
  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic                     load;

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r >= cap_r);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.last_pend = (remain_r == CW'(1));

  assign load = cmd.resp || cmd.emit;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    cap_nxt    = cap_r;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    if (cfg_we) begin
      cap_nxt   = eff_cap(cfg_wdata);
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.enq) begin
      tail_nxt  = adv(tail_r, cap_r);
      count_nxt = count_r + CW'(1);
    end else if (cmd.deq) begin
      rd_en      = 1'b1;
      head_nxt   = adv(head_r, cap_r);
      count_nxt  = count_r - CW'(1);
      remain_nxt = CW'(1);
    end else if (cmd.disp) begin
      rd_en      = 1'b1;
      idx_nxt    = adv(head_r, cap_r);
      remain_nxt = count_r;
    end else if (cmd.emit && !stat.last_pend) begin
      rd_en      = 1'b1;
      rd_addr    = idx_r;
      idx_nxt    = adv(idx_r, cap_r);
      remain_nxt = remain_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      remain_r    <= '0;
      cap_r       <= eff_cap(CAP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.enq) begin
      mem[tail_r] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_status_r <= cmd.resp_status;
      out_data_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.emit) begin
      out_status_r <= STATUS_OK;
      out_data_r   <= rd_data_r;
      out_last_r   <= stat.last_pend;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

### rtl/circular_queue_engine.sv
// Channel   Direction  Payload                   Request accepted when
// in_req    input      func, value               valid and ready high at clk
// out_rsp   output     status, data, last        valid and ready high at clk
// cfg       input      cfg_wdata (capacity)      cfg_we high at clk
//
// Enqueue and any request that ends in a status only load the response register
// directly. A dequeue or a display of N entries first reads an entry through the
// single registered read port of the slot memory; each entry is then emitted in turn.
// Reset is synchronous: the queue is empty and the capacity is min(64, DEPTH).
// A stalled result holds the output register, and no new request is taken then.
`default_nettype none

module circular_queue_engine import cqe_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  cqe_in_if.sink           in_req,
  cqe_out_if.source        out_rsp
);

  cqe_cmd_t  cmd;
  cqe_stat_t stat;

  cqe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_func  (in_req.func),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cqe_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_value   (in_req.value),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_rsp.valid),
    .out_ready  (out_rsp.ready),
    .out_status (out_rsp.status),
    .out_data   (out_rsp.data),
    .out_last   (out_rsp.last)
  );

endmodule

`default_nettype wire
